### src/pmg_pkg.sv
// Shared types, constants and table helpers of the Porod model pipeline.
package pmg_pkg;

    // Width of log2 Q in signed Q.28.
    localparam int LG_W = 34;
    // Width of the magnitude of ln Q in Q.28.
    localparam int LN_W = 33;
    // ln 2 in Q.30.
    localparam logic signed [63:0] LN2_Q30 = 64'sd744261118;
    localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

    // Register indexes of the configuration port.
    typedef enum logic [7:0] {
        REG_OFFSET_C0    = 8'd0,
        REG_SLOPE_C1     = 8'd1,
        REG_AMPLITUDE_C4 = 8'd2,
        REG_DIMENSION_D  = 8'd3
    } pmg_reg_t;

    // Side data that travels with every word through the pipeline.
    typedef struct packed {
        logic        zero;
        logic [31:0] q;
    } pmg_side_t;

    // Bit-by-bit base-2 logarithm of a Q1.30 mantissa in [1,2), 28 fraction bits.
    // Only used to build the constant tables.
    function automatic logic [31:0] bit_log2(input logic [63:0] m_in);
        logic [63:0] m;
        logic [31:0] y;
        m = m_in;
        y = '0;
        for (int k = 27; k >= 0; k--)
        begin
            m = (m * m) >> 30;
            if (m >= 64'h8000_0000)
            begin
                m = m >> 1;
                y[k] = 1'b1;
            end
        end
        return y;
    endfunction

endpackage

### src/pmg_rom.sv
// Constant interpolation table (log2 or exp2) with two read ports for neighbors.
module pmg_rom #(
    parameter int DEPTH     = 256,
    parameter bit EXP_TABLE = 1'b0
) (
    input  logic [$clog2(DEPTH)-1:0] k,
    output logic [31:0]              lo_entry,
    output logic [31:0]              hi_entry
);
    import pmg_pkg::*;

    localparam int IW = $clog2(DEPTH + 1);

    function automatic logic [31:0] log_entry(input int idx);
        logic [63:0] off;
        if (idx >= DEPTH)
            return 32'h1000_0000;
        off = (64'(idx) << 30) / DEPTH;
        return bit_log2(64'h4000_0000 + off);
    endfunction

    // Smallest mantissa whose log2 reaches the grid point.
    function automatic logic [31:0] exp_entry(input int idx);
        logic [63:0] target;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        if (idx >= DEPTH)
            return 32'h8000_0000;
        target = (64'(idx) << 28) / DEPTH;
        lo = 64'h4000_0000;
        hi = 64'h7FFF_FFFF;
        while (lo < hi)
        begin
            mid = (lo + hi) >> 1;
            if (64'(bit_log2(mid)) >= target)
                hi = mid;
            else
                lo = mid + 64'd1;
        end
        return lo[31:0];
    endfunction

    logic [31:0]   rom [DEPTH+1];
    logic [IW-1:0] k_lo;
    logic [IW-1:0] k_hi;

    for (genvar g = 0; g <= DEPTH; g++)
    begin : g_rom
        if (EXP_TABLE)
        begin : g_exp
            assign rom[g] = exp_entry(g);
        end
        else
        begin : g_log
            assign rom[g] = log_entry(g);
        end
    end

    assign k_lo     = IW'(k);
    assign k_hi     = k_lo + IW'(1);
    assign lo_entry = rom[k_lo];
    assign hi_entry = rom[k_hi];

endmodule

### src/pmg_log2.sv
// Five-stage log2 of Q: normalize, scale, table lookup, interpolate, assemble.
module pmg_log2 #(
    parameter int DEPTH = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_vld,
    input  logic [31:0]                   q,
    output logic                          out_vld,
    output logic signed [pmg_pkg::LG_W-1:0] lg2,
    output pmg_pkg::pmg_side_t            side
);
    import pmg_pkg::*;

    localparam int KW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);
    localparam int XW = 30 + NW;

    logic            v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    pmg_side_t       s1_reg, s2_reg, s3_reg, s4_reg, s5_reg;
    logic [4:0]      lead_next, lead2_reg, lead3_reg, lead4_reg;
    logic [31:0]     norm;
    logic [29:0]     f2_reg;
    logic [XW-1:0]   x_log;
    logic [KW-1:0]   k3_reg;
    logic [29:0]     r3_reg;
    logic [31:0]     lo_entry, hi_entry, diff;
    logic [58:0]     prod_next, prod4_reg;
    logic [28:0]     base4_reg, frac;
    logic signed [5:0] pexp;
    logic signed [LG_W-1:0] lg2_next, lg2_reg;

    // Stage 1 -> 2: position of the leading one and the mantissa fraction.
    always_comb
    begin
        lead_next = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (s1_reg.q[i])
                lead_next = 5'(i);
        end
    end
    assign norm = s1_reg.q << (5'd31 - lead_next);

    // Stage 2 -> 3: table index and remainder.
    assign x_log = XW'(f2_reg) * XW'(DEPTH);

    // Stage 3 -> 4: neighbors and slope times remainder.
    pmg_rom #(.DEPTH(DEPTH), .EXP_TABLE(1'b0)) u_log_rom (
        .k        (k3_reg),
        .lo_entry (lo_entry),
        .hi_entry (hi_entry)
    );
    assign diff      = hi_entry - lo_entry;
    assign prod_next = 59'(diff[28:0]) * 59'(r3_reg);

    // Stage 4 -> 5: integer part plus interpolated fraction.
    assign frac     = base4_reg + prod4_reg[58:30];
    assign pexp     = $signed({1'b0, lead4_reg}) - 6'sd24;
    assign lg2_next = $signed({pexp, 28'b0}) + $signed({5'b0, frac});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg.zero <= (q == 32'd0);
            s1_reg.q    <= q;
            s2_reg      <= s1_reg;
            lead2_reg   <= lead_next;
            f2_reg      <= norm[30:1];
            s3_reg      <= s2_reg;
            lead3_reg   <= lead2_reg;
            k3_reg      <= x_log[30 +: KW];
            r3_reg      <= x_log[29:0];
            s4_reg      <= s3_reg;
            lead4_reg   <= lead3_reg;
            base4_reg   <= lo_entry[28:0];
            prod4_reg   <= prod_next;
            s5_reg      <= s4_reg;
            lg2_reg     <= lg2_next;
        end
    end

    assign out_vld = v5_reg;
    assign lg2     = lg2_reg;
    assign side    = s5_reg;

endmodule

### src/pmg_pow.sv
// Four-stage power Q^(D-4) via exp2 of (D-4)*log2 Q, and ln Q alongside.
module pmg_pow #(
    parameter int DEPTH = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_vld,
    input  logic signed [pmg_pkg::LG_W-1:0] lg2,
    input  pmg_pkg::pmg_side_t              side_in,
    input  logic signed [15:0]              dimension_d,
    output logic                            out_vld,
    output logic [62:0]                     power,
    output logic                            ln_neg,
    output logic [pmg_pkg::LN_W-1:0]        ln_mag,
    output pmg_pkg::pmg_side_t              side_out
);
    import pmg_pkg::*;

    localparam int KW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);
    localparam int XW = 28 + NW;

    logic              v6_reg, v7_reg, v8_reg, v9_reg;
    pmg_side_t         s6_reg, s7_reg, s8_reg, s9_reg;
    logic signed [16:0] expo;
    logic signed [50:0] eprod_next, eprod6_reg;
    logic signed [63:0] lnprod_next, lnprod6_reg;
    logic signed [38:0] t_val;
    logic signed [33:0] lnq;
    logic [XW-1:0]     x_exp;
    logic signed [10:0] ti7_reg, ti8_reg;
    logic [KW-1:0]     k7_reg;
    logic [27:0]       r7_reg;
    logic              ln_neg7_reg, ln_neg8_reg, ln_neg9_reg;
    logic [LN_W-1:0]   ln_mag_next, ln_mag7_reg, ln_mag8_reg, ln_mag9_reg;
    logic [31:0]       lo_entry, hi_entry, diff, mant;
    logic [59:0]       prod_next, prod8_reg;
    logic [31:0]       base8_reg;
    logic signed [11:0] sh_amt;
    logic [11:0]       sh_right;
    logic [94:0]       wide;
    logic [62:0]       power_next, power9_reg;

    // Stage 5 -> 6: exponent times log2 Q, and log2 Q times ln 2.
    assign expo        = 17'(dimension_d) - 17'sd16384;
    assign eprod_next  = 51'(expo) * 51'(lg2);
    assign lnprod_next = 64'(lg2) * LN2_Q30;

    // Stage 6 -> 7: split into integer and fraction, locate the table entry.
    assign t_val = eprod6_reg[50:12];
    assign x_exp = XW'(t_val[27:0]) * XW'(DEPTH);
    assign lnq   = lnprod6_reg[63:30];
    assign ln_mag_next = lnq[33] ? LN_W'(-lnq) : LN_W'(lnq);

    // Stage 7 -> 8: neighbors and slope times remainder.
    pmg_rom #(.DEPTH(DEPTH), .EXP_TABLE(1'b1)) u_exp_rom (
        .k        (k7_reg),
        .lo_entry (lo_entry),
        .hi_entry (hi_entry)
    );
    assign diff      = hi_entry - lo_entry;
    assign prod_next = 60'(diff) * 60'(r7_reg);

    // Stage 8 -> 9: mantissa scaled by the integer part, saturating.
    assign mant     = base8_reg + prod8_reg[59:28];
    assign sh_amt   = 12'(ti8_reg) - 12'sd14;
    assign sh_right = 12'(-sh_amt);
    assign wide     = 95'(mant) << sh_amt[5:0];

    always_comb
    begin
        if (sh_amt < 0)
        begin
            if (sh_right >= 12'd63)
                power_next = '0;
            else
                power_next = 63'(mant) >> sh_right[5:0];
        end
        else if (sh_amt > 12'sd62 || (|wide[94:63]))
            power_next = SMAX[62:0];
        else
            power_next = wide[62:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
        end
        else if (en)
        begin
            v6_reg <= in_vld;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
            v9_reg <= v8_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_reg      <= side_in;
            eprod6_reg  <= eprod_next;
            lnprod6_reg <= lnprod_next;
            s7_reg      <= s6_reg;
            ti7_reg     <= t_val[38:28];
            k7_reg      <= x_exp[28 +: KW];
            r7_reg      <= x_exp[27:0];
            ln_neg7_reg <= lnq[33];
            ln_mag7_reg <= ln_mag_next;
            s8_reg      <= s7_reg;
            ti8_reg     <= ti7_reg;
            base8_reg   <= lo_entry;
            prod8_reg   <= prod_next;
            ln_neg8_reg <= ln_neg7_reg;
            ln_mag8_reg <= ln_mag7_reg;
            s9_reg      <= s8_reg;
            power9_reg  <= power_next;
            ln_neg9_reg <= ln_neg8_reg;
            ln_mag9_reg <= ln_mag8_reg;
        end
    end

    assign out_vld  = v9_reg;
    assign power    = power9_reg;
    assign ln_neg   = ln_neg9_reg;
    assign ln_mag   = ln_mag9_reg;
    assign side_out = s9_reg;

endmodule

### src/pmg_grad.sv
// Four-stage products and saturation for intensity and the D gradient.
module pmg_grad (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_vld,
    input  logic signed [31:0]       offset_c0,
    input  logic signed [31:0]       slope_c1,
    input  logic signed [31:0]       amplitude_c4,
    input  logic [62:0]              power,
    input  logic                     ln_neg,
    input  logic [pmg_pkg::LN_W-1:0] ln_mag,
    input  pmg_pkg::pmg_side_t       side,
    output logic                     out_vld,
    output logic signed [63:0]       intensity,
    output logic [62:0]              power_term,
    output logic signed [63:0]       grad_dimension,
    output logic                     q_invalid
);
    import pmg_pkg::*;

    logic            v10_reg, v11_reg, v12_reg, v13_reg;
    pmg_side_t       s10_reg, s11_reg, s12_reg;
    logic [62:0]     pw10_reg, pw11_reg, pw12_reg, pw13_reg;
    logic            ln_neg10_reg, ln_neg11_reg;
    logic [LN_W-1:0] ln_mag10_reg, ln_mag11_reg;
    logic            c4neg_next, c4neg10_reg, c4neg11_reg;
    logic [31:0]     c4mag;
    logic [63:0]     pp_lo_next, pp_lo10_reg;
    logic [62:0]     pp_hi_next, pp_hi10_reg;
    logic signed [64:0] c1q_next, c1q10_reg;
    logic [94:0]     full_next, full11_reg;
    logic signed [41:0] base_next, base11_reg;
    logic            psat;
    logic [63:0]     pmag;
    logic signed [66:0] psigned, isum;
    logic [63:0]     int_next, int12_reg, int13_reg;
    logic [78:0]     amag;
    logic [64:0]     g0_next, g0_reg, g1_next, g1_reg;
    logic [47:0]     g2_next, g2_reg;
    logic            gneg12_reg;
    logic [111:0]    gprod;
    logic [63:0]     gmag, grad_next, grad13_reg;
    logic            inv13_reg;

    // Stage 9 -> 10: |c4| times the power in two halves, c1 times Q.
    assign c4neg_next = amplitude_c4[31];
    assign c4mag      = c4neg_next ? 32'(-amplitude_c4) : 32'(amplitude_c4);
    assign pp_lo_next = 64'(c4mag) * 64'(power[31:0]);
    assign pp_hi_next = 63'(c4mag) * 63'(power[62:32]);
    assign c1q_next   = 65'(slope_c1) * $signed({33'b0, side.q});

    // Stage 10 -> 11: join the halves, add the linear part to the offset.
    assign full_next = 95'(pp_lo10_reg) + {pp_hi10_reg, 32'b0};
    assign base_next = 42'(offset_c0) + 42'($signed(c1q10_reg[64:24]));

    // Stage 11 -> 12: amplitude term to Q.16 and the saturating sum;
    // the D gradient product is started in three partial products.
    assign psat    = |full11_reg[94:80];
    assign pmag    = psat ? '1 : full11_reg[79:16];
    assign psigned = $signed({3'b0, pmag});
    assign isum    = 67'(base11_reg) + (c4neg11_reg ? -psigned : psigned);

    always_comb
    begin
        if (isum > $signed({3'b0, SMAX}))
            int_next = SMAX;
        else if (isum < -$signed({3'b0, SMIN}))
            int_next = SMIN;
        else
            int_next = isum[63:0];
    end

    assign amag    = full11_reg[94:16];
    assign g0_next = 65'(amag[31:0]) * 65'(ln_mag11_reg);
    assign g1_next = 65'(amag[63:32]) * 65'(ln_mag11_reg);
    assign g2_next = 48'(amag[78:64]) * 48'(ln_mag11_reg);

    // Stage 12 -> 13: sum the partial products, drop 28 bits, saturate.
    assign gprod = 112'(g0_reg) + (112'(g1_reg) << 32) + (112'(g2_reg) << 64);
    assign gmag  = (|gprod[111:92]) ? '1 : gprod[91:28];

    always_comb
    begin
        if (gneg12_reg)
            grad_next = (gmag > SMIN) ? SMIN : 64'(-gmag);
        else
            grad_next = gmag[63] ? SMAX : gmag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v10_reg <= 1'b0;
            v11_reg <= 1'b0;
            v12_reg <= 1'b0;
            v13_reg <= 1'b0;
        end
        else if (en)
        begin
            v10_reg <= in_vld;
            v11_reg <= v10_reg;
            v12_reg <= v11_reg;
            v13_reg <= v12_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s10_reg      <= side;
            pw10_reg     <= power;
            ln_neg10_reg <= ln_neg;
            ln_mag10_reg <= ln_mag;
            c4neg10_reg  <= c4neg_next;
            pp_lo10_reg  <= pp_lo_next;
            pp_hi10_reg  <= pp_hi_next;
            c1q10_reg    <= c1q_next;
            s11_reg      <= s10_reg;
            pw11_reg     <= pw10_reg;
            ln_neg11_reg <= ln_neg10_reg;
            ln_mag11_reg <= ln_mag10_reg;
            c4neg11_reg  <= c4neg10_reg;
            full11_reg   <= full_next;
            base11_reg   <= base_next;
            s12_reg      <= s11_reg;
            pw12_reg     <= pw11_reg;
            int12_reg    <= int_next;
            g0_reg       <= g0_next;
            g1_reg       <= g1_next;
            g2_reg       <= g2_next;
            gneg12_reg   <= c4neg11_reg ^ ln_neg11_reg;
            // A zero Q forces every numeric result to zero.
            inv13_reg    <= s12_reg.zero;
            pw13_reg     <= s12_reg.zero ? '0 : pw12_reg;
            int13_reg    <= s12_reg.zero ? '0 : int12_reg;
            grad13_reg   <= s12_reg.zero ? '0 : grad_next;
        end
    end

    assign out_vld        = v13_reg;
    assign intensity      = $signed(int13_reg);
    assign power_term     = pw13_reg;
    assign grad_dimension = $signed(grad13_reg);
    assign q_invalid      = inv13_reg;

endmodule

### src/porod_model_with_gradient.sv
// Top level of the Porod model evaluator with gradient outputs.
//
// Usage: each word on the item channel (item_valid/item_stall) carries one
// scattering vector q in unsigned Q8.24. Each word on the result channel
// (result_valid/result_stall) carries c0 + c1*Q + c4*Q^(D-4), the power term,
// the D gradient and the invalid flag for a zero Q, in the order accepted.
// The four model coefficients are written through the cfg port; the port is
// always ready, and an index past the last register is ignored.
// One word is accepted in every cycle unless a held result word freezes the
// pipeline; from acceptance to result_valid a word passes the 13 register
// stages of log2 lookup, exp2 lookup and the split wide multiplies.
// While a result word is held by result_stall the whole pipeline freezes and
// item_stall is raised; nothing is dropped or repeated. Reset clears all
// valid bits and loads the coefficient defaults (amplitude 1.0, others 0).
module porod_model_with_gradient #(
    parameter int APPROX_TABLE_DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [31:0]        q,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [63:0] intensity,
    output logic [62:0]        power_term,
    output logic signed [63:0] grad_dimension,
    output logic               q_invalid,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import pmg_pkg::*;

    logic signed [31:0] offset_c0_reg, slope_c1_reg, amplitude_c4_reg;
    logic signed [15:0] dimension_d_reg;
    logic               en;

    logic                   lg_vld;
    logic signed [LG_W-1:0] lg2;
    pmg_side_t              lg_side;
    logic                   pw_vld;
    logic [62:0]            power;
    logic                   ln_neg;
    logic [LN_W-1:0]        ln_mag;
    pmg_side_t              pw_side;

    // The pipeline advances unless a finished word is being held.
    assign en         = ~(result_valid & result_stall);
    assign item_stall = ~en;
    assign cfg_ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_c0_reg    <= '0;
            slope_c1_reg     <= '0;
            amplitude_c4_reg <= 32'sd65536;
            dimension_d_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_OFFSET_C0:    offset_c0_reg    <= $signed(cfg_data);
                REG_SLOPE_C1:     slope_c1_reg     <= $signed(cfg_data);
                REG_AMPLITUDE_C4: amplitude_c4_reg <= $signed(cfg_data);
                REG_DIMENSION_D:  dimension_d_reg  <= $signed(cfg_data[15:0]);
                default:          ;
            endcase
        end
    end

    pmg_log2 #(.DEPTH(APPROX_TABLE_DEPTH)) u_log2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (item_valid),
        .q       (q),
        .out_vld (lg_vld),
        .lg2     (lg2),
        .side    (lg_side)
    );

    pmg_pow #(.DEPTH(APPROX_TABLE_DEPTH)) u_pow (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_vld      (lg_vld),
        .lg2         (lg2),
        .side_in     (lg_side),
        .dimension_d (dimension_d_reg),
        .out_vld     (pw_vld),
        .power       (power),
        .ln_neg      (ln_neg),
        .ln_mag      (ln_mag),
        .side_out    (pw_side)
    );

    pmg_grad u_grad (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .in_vld         (pw_vld),
        .offset_c0      (offset_c0_reg),
        .slope_c1       (slope_c1_reg),
        .amplitude_c4   (amplitude_c4_reg),
        .power          (power),
        .ln_neg         (ln_neg),
        .ln_mag         (ln_mag),
        .side           (pw_side),
        .out_vld        (result_valid),
        .intensity      (intensity),
        .power_term     (power_term),
        .grad_dimension (grad_dimension),
        .q_invalid      (q_invalid)
    );

endmodule

### dv/porod_model_with_gradient_test.sv
// Testbench for the Porod model pipeline: random and directed Q words checked against a predictor.
module porod_model_with_gradient_test;

    import pmg_pkg::*;

    localparam int DEPTH = 256;
    localparam int PIPE_LAT = 13;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [63:0] intensity;
        logic [62:0]        power_term;
        logic signed [63:0] grad_dimension;
        logic               q_invalid;
    } porod_result_t;

    // The scoreboard holds its own copy of the coefficients and tables, predicts
    // the result of every accepted Q word and checks returned words in order.
    class porod_scoreboard;
        logic [31:0] log_tab[DEPTH + 1];
        logic [31:0] exp_tab[DEPTH + 1];
        logic signed [31:0] c0, c1, c4;
        logic signed [15:0] dim;
        porod_result_t pending[$];
        int errors;

        function new();
            longint unsigned target, lo, hi, mid;
            for (int i = 0; i < DEPTH; i++)
            begin
                target = (longint'(i) << 28) / DEPTH;
                log_tab[i] = frac_log2((64'd1 << 30) + (longint'(i) << 30) / DEPTH);
                lo = 64'd1 << 30;
                hi = (64'd1 << 31) - 1;
                while (lo < hi)
                begin
                    mid = (lo + hi) >> 1;
                    if (frac_log2(mid) >= target)
                        hi = mid;
                    else
                        lo = mid + 1;
                end
                exp_tab[i] = lo[31:0];
            end
            log_tab[DEPTH] = 32'd1 << 28;
            exp_tab[DEPTH] = 32'h8000_0000;
            c0 = 0;
            c1 = 0;
            c4 = 32'sd65536;
            dim = 0;
            errors = 0;
        endfunction

        function logic [31:0] frac_log2(longint unsigned m);
            logic [31:0] y;
            y = 0;
            for (int k = 27; k >= 0; k--)
            begin
                m = (m * m) >> 30;
                if (m >= (64'd2 << 30))
                begin
                    m = m >> 1;
                    y[k] = 1'b1;
                end
            end
            return y;
        endfunction

        function longint lookup(bit from_exp, longint unsigned frac, int bits);
            longint unsigned x, k;
            longint r, d, lo_v, hi_v;
            x = frac * DEPTH;
            k = x >> bits;
            r = longint'(x & ((64'd1 << bits) - 1));
            if (k >= DEPTH)
                k = DEPTH - 1;
            lo_v = from_exp ? longint'(exp_tab[k]) : longint'(log_tab[k]);
            hi_v = from_exp ? longint'(exp_tab[k + 1]) : longint'(log_tab[k + 1]);
            d = hi_v - lo_v;
            return lo_v + ((d * r) >>> bits);
        endfunction

        function logic [63:0] clamp_add(longint base, bit neg, logic [63:0] mag);
            logic signed [65:0] v;
            v = neg ? 66'(signed'(base)) - $signed({2'b00, mag})
                    : 66'(signed'(base)) + $signed({2'b00, mag});
            if (v > $signed({2'b00, SMAX}))
                return SMAX;
            if (v < -$signed({2'b00, SMIN}))
                return SMIN;
            return v[63:0];
        endfunction

        function void write_reg(logic [7:0] idx, logic [31:0] data);
            case (idx)
                REG_OFFSET_C0:    c0 = data;
                REG_SLOPE_C1:     c1 = data;
                REG_AMPLITUDE_C4: c4 = data;
                REG_DIMENSION_D:  dim = data[15:0];
                default: ;
            endcase
        endfunction

        // Notes an accepted Q word and queues its expected result.
        function void note_q(logic [31:0] qv);
            porod_result_t r;
            int p, s;
            longint e, lg2, t, ti, lnq, base;
            longint unsigned m, tf, mant, power, c4mag, lnmag;
            logic [127:0] prod;
            logic [191:0] wide;
            logic [63:0] pmag, gmag;
            if (qv == 0)
            begin
                r = '{0, 0, 0, 1'b1};
                pending.push_back(r);
                return;
            end
            e = longint'(dim) - 16384;
            p = 31;
            while (qv[p] == 1'b0)
                p--;
            m = (p <= 30) ? (longint'(qv) << (30 - p)) : (longint'(qv) >> 1);
            lg2 = longint'(p - 24) * (64'sd1 <<< 28) + lookup(0, m - (64'd1 << 30), 30);
            t = (e * lg2) >>> 12;
            ti = t >>> 28;
            tf = t & ((64'd1 << 28) - 1);
            mant = lookup(1, tf, 28);
            s = int'(ti - 14);
            if (s >= 0)
                power = (s > 62 || (mant >> (63 - s)) != 0) ? SMAX : mant << s;
            else
                power = (-s >= 63) ? 0 : mant >> (-s);
            lnq = (lg2 * 744261118) >>> 30;
            c4mag = c4 < 0 ? longint'(-longint'(c4)) : longint'(c4);
            prod = 128'(c4mag) * 128'(power);
            pmag = (prod[127:80] != 0) ? '1 : prod[79:16];
            base = longint'(c0) + ((longint'(c1) * longint'(qv)) >>> 24);
            r.intensity = clamp_add(base, c4 < 0, pmag);
            r.power_term = power[62:0];
            lnmag = lnq < 0 ? -lnq : lnq;
            wide = 192'(prod >> 16) * 192'(lnmag);
            gmag = (wide[127:92] != 0) ? '1 : wide[91:28];
            r.grad_dimension = clamp_add(0, (c4 < 0) != (lnq < 0), gmag);
            r.q_invalid = 1'b0;
            pending.push_back(r);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch on %s: got %h, expected %h", what, got, want);
            errors++;
        endtask

        task check_result(porod_result_t got);
            porod_result_t want;
            if (pending.size() == 0)
            begin
                report("unexpected word", '0, '0);
                return;
            end
            want = pending.pop_front();
            if (got.intensity !== want.intensity)
                report("intensity", got.intensity, want.intensity);
            if (got.power_term !== want.power_term)
                report("power_term", 64'(got.power_term), 64'(want.power_term));
            if (got.grad_dimension !== want.grad_dimension)
                report("grad_dimension", got.grad_dimension, want.grad_dimension);
            if (got.q_invalid !== want.q_invalid)
                report("q_invalid", 64'(got.q_invalid), 64'(want.q_invalid));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic item_valid;
    logic item_stall;
    logic [31:0] q;
    logic result_valid;
    logic result_stall;
    logic signed [63:0] intensity;
    logic [62:0] power_term;
    logic signed [63:0] grad_dimension;
    logic q_invalid;
    logic cfg_valid;
    logic cfg_ready;
    logic [7:0] cfg_index;
    logic [31:0] cfg_data;

    porod_scoreboard sb = new();
    int cycles = 0;
    int hold_left = 0;     // cycles the receiver still has to hold off
    int hold_reqs = 0;     // long holds requested by the stimulus
    int holds_done = 0;    // long holds the receiver has started
    bit no_idle = 0;       // set during the stretch without random gaps

    porod_model_with_gradient u_top (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .q(q),
        .result_valid(result_valid), .result_stall(result_stall),
        .intensity(intensity), .power_term(power_term),
        .grad_dimension(grad_dimension), .q_invalid(q_invalid),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // The timeout guard runs alongside everything else.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver side: random stalls, plus a long hold when one is requested.
    always @(posedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else if (holds_done != hold_reqs)
        begin
            holds_done <= hold_reqs;
            hold_left <= 299;
            result_stall <= 1'b1;
        end
        else
            result_stall <= !no_idle && ($urandom_range(0, 99) < 12);
    end

    // Every result word accepted at this edge is checked against the oldest expectation.
    always @(posedge clk)
    begin
        porod_result_t got;
        if (rst_n && result_valid && !result_stall)
        begin
            got.intensity = intensity;
            got.power_term = power_term;
            got.grad_dimension = grad_dimension;
            got.q_invalid = q_invalid;
            sb.check_result(got);
        end
    end

    // Offers one Q word and holds it until the block takes it.
    task send_q(logic [31:0] v);
        item_valid <= 1'b1;
        q <= v;
        do
            @(posedge clk);
        while (item_stall);
        sb.note_q(v);
        if (!no_idle && $urandom_range(0, 99) < 4)
        begin
            item_valid <= 1'b0;
            q <= $urandom;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
        end
    endtask

    task write_cfg(logic [7:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Lets the pipeline drain fully before any register is touched.
    task drain;
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 4)
            @(posedge clk);
    endtask

    function logic [31:0] rand_q();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom >> $urandom_range(0, 31);
            2: return 32'h0100_0000 + $urandom_range(0, 4095) - 2048;
            default: return ($urandom_range(0, 49) == 0) ? 32'd0 : $urandom >> $urandom_range(8, 24);
        endcase
    endfunction

    initial
    begin
        logic signed [15:0] dims[6];
        rst_n = 1'b0;
        item_valid <= 1'b0;
        q <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words under the reset coefficients: zero Q, extremes, near one.
        send_q(32'd0);
        send_q(32'd1);
        send_q(32'hFFFF_FFFF);
        send_q(32'h8000_0000);
        send_q(32'h0100_0000);
        send_q(32'h00FF_FFFF);
        send_q(32'h0100_0001);
        send_q(32'd2);
        drain();

        // Extreme coefficients: saturation of the power term and of both sums.
        write_cfg(REG_OFFSET_C0, 32'h7FFF_FFFF);
        write_cfg(REG_SLOPE_C1, 32'h7FFF_FFFF);
        write_cfg(REG_AMPLITUDE_C4, 32'h7FFF_FFFF);
        write_cfg(REG_DIMENSION_D, 32'h0000_8000);
        send_q(32'd1);
        send_q(32'hFFFF_FFFF);
        send_q(32'd0);
        send_q(32'h0000_0100);
        drain();
        write_cfg(REG_OFFSET_C0, 32'h8000_0000);
        write_cfg(REG_SLOPE_C1, 32'h8000_0000);
        write_cfg(REG_AMPLITUDE_C4, 32'h8000_0000);
        write_cfg(REG_DIMENSION_D, 32'h0000_7FFF);
        write_cfg(8'd4, 32'h1234_5678);
        write_cfg(8'd255, 32'hFFFF_FFFF);
        send_q(32'd1);
        send_q(32'hFFFF_FFFF);
        send_q(32'h0000_0003);
        send_q(32'h0200_0000);
        drain();

        dims = '{16'sh8000, 16'sh7FFF, 16'sh4000, 16'sh0000, 16'sh3800, 16'shC000};
        for (int ph = 0; ph < 8; ph++)
        begin
            write_cfg(REG_OFFSET_C0, $urandom);
            write_cfg(REG_SLOPE_C1, $urandom >> $urandom_range(0, 31));
            write_cfg(REG_AMPLITUDE_C4, (ph == 1) ? 32'h0001_0000 : $urandom >> $urandom_range(0, 16));
            write_cfg(REG_DIMENSION_D, (ph < 6) ? dims[ph] : $urandom_range(0, 65535));
            for (int n = 0; n < 215; n++)
            begin
                no_idle = (ph == 2);
                if (ph == 3 && n == 50)
                    hold_reqs++;
                if (ph == 4 && n == 100)
                begin
                    item_valid <= 1'b0;
                    @(posedge clk);
                    while (sb.pending.size() != 0)
                        @(posedge clk);
                end
                send_q(rand_q());
            end
            no_idle = 0;
            drain();
        end

        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
